>>> rtl/core/otb_pkg.sv
// otb_pkg: shared types and constants of the otsu threshold binarizer
// used by otb_hist, otb_mul and otsu_threshold_binarizer; no dependencies
package otb_pkg;

   localparam int GRAY_LEVELS = 256;
   localparam int MAX_PIXELS  = 1048576;

   localparam int LVL_W  = 8;
   localparam int CNT_W  = 21;
   localparam int SUM_W  = 28;
   localparam int PROD_W = 48;
   localparam int DEN_W  = 42;
   localparam int D2_W   = 96;
   localparam int A_W    = 96;
   localparam int B_W    = 48;
   localparam int P_W    = 144;

   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_FINISH   = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;
   localparam logic [1:0] CMD_CLEAR    = 2'd3;

   localparam logic [7:0] PIX_BG = 8'd0;
   localparam logic [7:0] PIX_FG = 8'd255;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [7:0] threshold;
      logic [7:0] binary_pixel;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [LVL_W-1:0] addr;
      logic [CNT_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic           start;
      logic [A_W-1:0] a;
      logic [B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic           done;
      logic [P_W-1:0] product;
   } mul_rsp_type;

endpackage

>>> rtl/core/otsu_threshold_binarizer.sv
// otsu_threshold_binarizer: histogram load, otsu threshold search, binarize
// depends on otb_pkg, otb_hist, otb_mul
//
// request beats carry a command and a pixel; response beats carry threshold,
// binary pixel and overflow. a beat moves when valid is high and stall low.
// load: histogram read then write back, no response; loads past
// capacity are dropped and set overflow. classify: one response beat in
// the next cycle. clear: no response, starts a clearing pass over the
// histogram memory. finish: one response beat after a search that sums
// the histogram and then, for each threshold with both classes occupied,
// computes six shift-add products through one shared multiplier.
// after reset the same clearing pass runs; req_stall is high while it
// runs and while a load, a finish or a clear is in progress.
// a stalled response holds in the output register; a new request is taken
// while it waits only if the receiver takes it in that same cycle.
module otsu_threshold_binarizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  otb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output otb_pkg::rsp_type rsp_data
);
   import otb_pkg::*;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_LOAD, S_SUM, S_SCAN_RD, S_SCAN_ACC, S_EVAL, S_MUL_GO, S_MUL_WAIT
   } state_type;

   typedef enum logic [2:0] {M_X, M_Y, M_DEN, M_D2, M_LHS, M_RHS} step_type;

   state_type        state_ff;
   step_type         step_ff;
   logic [LVL_W-1:0] clr_idx_ff;
   logic [LVL_W-1:0] ld_addr_ff;
   logic [LVL_W:0]   sum_idx_ff;
   logic [LVL_W-1:0] t_ff;
   logic [CNT_W-1:0] pixel_count_ff;
   logic [7:0]       best_thr_ff;
   logic             bg_ff;
   logic             first_ff;
   logic             dropped_ff;
   logic [CNT_W-1:0] tot_w_ff;
   logic [SUM_W-1:0] tot_s_ff;
   logic [CNT_W-1:0] wb_ff;
   logic [SUM_W-1:0] sb_ff;
   logic [PROD_W-1:0] x_ff;
   logic [PROD_W-1:0] d_ff;
   logic [DEN_W-1:0] den_ff;
   logic [D2_W-1:0]  d2_ff;
   logic [P_W-1:0]   lhs_ff;
   logic [D2_W-1:0]  best_d2_ff;
   logic [DEN_W-1:0] best_den_ff;
   logic [LVL_W-1:0] best_t_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   mem_wr_type       mem_wr;
   logic [LVL_W-1:0] rd_addr;
   logic [CNT_W-1:0] hist_q;
   mul_req_type      mul_req;
   mul_rsp_type      mul_rsp;

   logic                   req_accept;
   logic                   rsp_take;
   logic                   rsp_set;
   logic [LVL_W-1:0]       sum_prev;
   logic [LVL_W-1:0]       t_prev;
   logic [CNT_W+LVL_W-1:0] sum_term;
   logic [CNT_W+LVL_W-1:0] scan_term;
   logic [CNT_W-1:0]       wf;
   logic [SUM_W-1:0]       sf;
   logic [PROD_W-1:0]      y_val;
   logic                   cls;
   logic                   bg_eff;
   logic                   upd;
   logic                   last_t;

   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign sum_prev  = LVL_W'(sum_idx_ff - 1'b1);
   assign t_prev    = t_ff - 1'b1;
   assign sum_term  = hist_q * sum_prev;
   assign scan_term = hist_q * t_prev;
   assign wf        = tot_w_ff - wb_ff;
   assign sf        = tot_s_ff - sb_ff;
   assign y_val     = PROD_W'(mul_rsp.product);
   assign upd       = lhs_ff > mul_rsp.product;
   assign last_t    = (t_ff == LVL_W'(GRAY_LEVELS - 1));
   assign cls       = req_data.pixel_value < best_thr_ff;
   assign bg_eff    = first_ff ? bg_ff : cls;

   always_comb begin
      case (state_ff)
         S_IDLE:     rsp_set = req_accept && (req_data.command == CMD_CLASSIFY);
         S_EVAL:     rsp_set = (wb_ff == '0 || wf == '0) && last_t;
         S_MUL_WAIT: rsp_set = mul_rsp.done && (step_ff == M_RHS) && last_t;
         default:    rsp_set = 1'b0;
      endcase
   end

   always_comb begin
      case (state_ff)
         S_IDLE:    rd_addr = req_data.pixel_value;
         S_SUM:     rd_addr = sum_idx_ff[LVL_W-1:0];
         S_SCAN_RD: rd_addr = t_prev;
         default:   rd_addr = '0;
      endcase
   end

   always_comb begin
      mem_wr.en   = 1'b0;
      mem_wr.addr = ld_addr_ff;
      mem_wr.data = hist_q + 1'b1;
      if (state_ff == S_CLR) begin
         mem_wr.en   = 1'b1;
         mem_wr.addr = clr_idx_ff;
         mem_wr.data = '0;
      end else if (state_ff == S_LOAD) begin
         mem_wr.en = 1'b1;
      end
   end

   always_comb begin
      mul_req.start = (state_ff == S_MUL_GO);
      case (step_ff)
         M_X: begin
            mul_req.a = A_W'(sf);
            mul_req.b = B_W'(wb_ff);
         end
         M_Y: begin
            mul_req.a = A_W'(sb_ff);
            mul_req.b = B_W'(wf);
         end
         M_DEN: begin
            mul_req.a = A_W'(wb_ff);
            mul_req.b = B_W'(wf);
         end
         M_D2: begin
            mul_req.a = A_W'(d_ff);
            mul_req.b = B_W'(d_ff);
         end
         M_LHS: begin
            mul_req.a = d2_ff;
            mul_req.b = B_W'(best_den_ff);
         end
         default: begin
            mul_req.a = best_d2_ff;
            mul_req.b = B_W'(den_ff);
         end
      endcase
   end

   otb_hist u_hist (
      .clock   (clock),
      .mem_wr  (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (hist_q)
   );

   otb_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLR;
         step_ff        <= M_X;
         clr_idx_ff     <= '0;
         pixel_count_ff <= '0;
         best_thr_ff    <= '0;
         bg_ff          <= 1'b0;
         first_ff       <= 1'b0;
         dropped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         best_den_ff    <= DEN_W'(1);
      end else begin
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == LVL_W'(GRAY_LEVELS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  case (req_data.command)
                     CMD_LOAD: begin
                        if (pixel_count_ff >= CNT_W'(MAX_PIXELS)) begin
                           dropped_ff <= 1'b1;
                        end else begin
                           ld_addr_ff <= req_data.pixel_value;
                           state_ff   <= S_LOAD;
                        end
                     end
                     CMD_FINISH: begin
                        sum_idx_ff  <= '0;
                        tot_w_ff    <= '0;
                        tot_s_ff    <= '0;
                        best_d2_ff  <= '0;
                        best_den_ff <= DEN_W'(1);
                        best_t_ff   <= '0;
                        state_ff    <= S_SUM;
                     end
                     CMD_CLASSIFY: begin
                        if (!first_ff) begin
                           bg_ff    <= cls;
                           first_ff <= 1'b1;
                        end
                        rsp_data_ff.threshold    <= best_thr_ff;
                        rsp_data_ff.binary_pixel <= (cls == bg_eff) ? PIX_BG : PIX_FG;
                        rsp_data_ff.overflow     <= dropped_ff;
                     end
                     default: begin
                        clr_idx_ff     <= '0;
                        pixel_count_ff <= '0;
                        best_thr_ff    <= '0;
                        bg_ff          <= 1'b0;
                        first_ff       <= 1'b0;
                        dropped_ff     <= 1'b0;
                        state_ff       <= S_CLR;
                     end
                  endcase
               end
            end
            S_LOAD: begin
               pixel_count_ff <= pixel_count_ff + 1'b1;
               state_ff       <= S_IDLE;
            end
            S_SUM: begin
               sum_idx_ff <= sum_idx_ff + 1'b1;
               if (sum_idx_ff != '0) begin
                  tot_w_ff <= tot_w_ff + hist_q;
                  tot_s_ff <= tot_s_ff + SUM_W'(sum_term);
               end
               if (sum_idx_ff == (LVL_W+1)'(GRAY_LEVELS)) begin
                  t_ff     <= LVL_W'(1);
                  wb_ff    <= '0;
                  sb_ff    <= '0;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_ACC;
            end
            S_SCAN_ACC: begin
               wb_ff    <= wb_ff + hist_q;
               sb_ff    <= sb_ff + SUM_W'(scan_term);
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               if (wb_ff == '0 || wf == '0) begin
                  if (last_t) begin
                     best_thr_ff              <= best_t_ff;
                     first_ff                 <= 1'b0;
                     rsp_data_ff.threshold    <= best_t_ff;
                     rsp_data_ff.binary_pixel <= PIX_BG;
                     rsp_data_ff.overflow     <= dropped_ff;
                     state_ff                 <= S_IDLE;
                  end else begin
                     t_ff     <= t_ff + 1'b1;
                     state_ff <= S_SCAN_RD;
                  end
               end else begin
                  step_ff  <= M_X;
                  state_ff <= S_MUL_GO;
               end
            end
            S_MUL_GO: begin
               state_ff <= S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
               if (mul_rsp.done) begin
                  state_ff <= S_MUL_GO;
                  case (step_ff)
                     M_X: begin
                        x_ff    <= PROD_W'(mul_rsp.product);
                        step_ff <= M_Y;
                     end
                     M_Y: begin
                        d_ff    <= (x_ff >= y_val) ? x_ff - y_val : y_val - x_ff;
                        step_ff <= M_DEN;
                     end
                     M_DEN: begin
                        den_ff  <= DEN_W'(mul_rsp.product);
                        step_ff <= M_D2;
                     end
                     M_D2: begin
                        d2_ff   <= D2_W'(mul_rsp.product);
                        step_ff <= M_LHS;
                     end
                     M_LHS: begin
                        lhs_ff  <= mul_rsp.product;
                        step_ff <= M_RHS;
                     end
                     default: begin
                        step_ff <= M_X;
                        if (upd) begin
                           best_d2_ff  <= d2_ff;
                           best_den_ff <= den_ff;
                           best_t_ff   <= t_ff;
                        end
                        if (last_t) begin
                           best_thr_ff              <= upd ? t_ff : best_t_ff;
                           first_ff                 <= 1'b0;
                           rsp_data_ff.threshold    <= upd ? t_ff : best_t_ff;
                           rsp_data_ff.binary_pixel <= PIX_BG;
                           rsp_data_ff.overflow     <= dropped_ff;
                           state_ff                 <= S_IDLE;
                        end else begin
                           t_ff     <= t_ff + 1'b1;
                           state_ff <= S_SCAN_RD;
                        end
                     end
                  endcase
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      pixel_count_ff <= CNT_W'(MAX_PIXELS))
      else $error("pixel count above capacity");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == S_MUL_WAIT)
      else $error("multiplier finished outside its wait state");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      best_den_ff != '0)
      else $error("best denominator is zero");

   a_clear_pass: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.command == CMD_CLEAR |=> state_ff == S_CLR && clr_idx_ff == '0)
      else $error("clear did not start a clearing pass");
`endif

endmodule

>>> rtl/core/otb_hist.sv
// otb_hist: histogram memory, one write and one registered read per cycle
// depends on otb_pkg
module otb_hist (
   input  logic                        clock,
   input  otb_pkg::mem_wr_type         mem_wr,
   input  logic [otb_pkg::LVL_W-1:0]   rd_addr,
   output logic [otb_pkg::CNT_W-1:0]   rd_data
);
   import otb_pkg::*;

   logic [CNT_W-1:0] mem [GRAY_LEVELS];
   logic [CNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.addr] <= mem_wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/otb_mul.sv
// otb_mul: shift-add multiplier, one multiplier bit per cycle, stops early
// depends on otb_pkg
module otb_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  otb_pkg::mul_req_type mul_req,
   output otb_pkg::mul_rsp_type mul_rsp
);
   import otb_pkg::*;

   logic           busy_ff;
   logic [P_W-1:0] a_ff;
   logic [B_W-1:0] b_ff;
   logic [P_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (mul_req.start) begin
         a_ff    <= P_W'(mul_req.a);
         b_ff    <= mul_req.b;
         acc_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_ff <= acc_ff + a_ff;
            end
            a_ff <= a_ff << 1;
            b_ff <= b_ff >> 1;
         end
      end
   end

   assign mul_rsp.done    = busy_ff && (b_ff == '0);
   assign mul_rsp.product = acc_ff;

endmodule
